FILE: hdl/bcba_pkg.sv
// ----------------------------------------------------------------------------
// bcba_pkg
// Shared types and codes for the contiguous block allocator.
// ----------------------------------------------------------------------------
package bcba_pkg;

  localparam int FW = 11;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_MARK  = 2'd2;

  // running state of the free-run search
  typedef struct packed {
    logic [FW-1:0] run;
    logic [FW-1:0] best_len;
    logic [FW-1:0] best_first;
  } scan_st_t;

  typedef struct packed {
    logic          found;
    logic [FW-1:0] first;
  } scan_hit_t;

endpackage

FILE: hdl/bcba_scan_unit.sv
// ----------------------------------------------------------------------------
// bcba_scan_unit
// Walks one byte of the used map, extending the current free run and
// tracking the longest run seen; flags the first run that reaches the length.
// ----------------------------------------------------------------------------
module bcba_scan_unit (
  input  logic [7:0]                 row_bits,
  input  logic [bcba_pkg::FW-1:0]    base,
  input  logic [bcba_pkg::FW-1:0]    req_len,
  input  bcba_pkg::scan_st_t         st_in,
  output bcba_pkg::scan_st_t         st_out,
  output bcba_pkg::scan_hit_t        hit
);
  import bcba_pkg::*;

  always_comb begin
    logic [FW-1:0] run;
    logic [FW-1:0] bl;
    logic [FW-1:0] bf;
    logic          found;
    logic [FW-1:0] ff;
    logic [FW-1:0] idx;
    run   = st_in.run;
    bl    = st_in.best_len;
    bf    = st_in.best_first;
    found = 1'b0;
    ff    = '0;
    for (int k = 0; k < 8; k++) begin
      idx = base + FW'(k);
      if (!found) begin
        if (!row_bits[k]) begin
          run = run + 1'b1;
          if (run == req_len) begin
            found = 1'b1;
            ff    = idx + 1'b1 - req_len;
          end
        end else begin
          if (run > bl) begin
            bl = run;
            bf = idx - run;
          end
          run = '0;
        end
      end
    end
    st_out.run        = run;
    st_out.best_len   = bl;
    st_out.best_first = bf;
    hit.found         = found;
    hit.first         = ff;
  end

endmodule

FILE: hdl/bitmap_contiguous_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_contiguous_block_allocator
// One-bit-per-block used map with first-fit contiguous run allocation.
// ----------------------------------------------------------------------------
// Input items arrive on s_tvalid/s_tready/s_tdata: allocate, free or mark a
// run. Every item gives exactly one result on m_tvalid/m_tready/m_tdata:
// the 1-based start and length allocated, or zeros for free, mark, unused
// codes, zero-length allocates and allocates that find no free block; an
// allocate with no run of the full length takes the longest free run found.
// cfg_valid/cfg_ready/cfg_data write blocks_in_use; it is always ready. The
// user must see it is only written while idle; the block does not check.
// The map is a byte-wide memory, (NUM_BLOCKS+7)/8 rows. After reset a
// clearing pass writes every row to zero, with s_tready low. One item at a
// time: an allocate reads one row a cycle through the byte scan unit over
// min(blocks_in_use, NUM_BLOCKS)/8 rows, then sets up the mark, reads and
// writes each row touched and loads the result. A zero-length allocate or
// one that finds no free block skips the marking; free and mark use the same
// marking steps. A finished result sits in the output register while the
// next item is taken; if the receiver stalls, the following result waits
// until the register empties, and s_tready stays low meanwhile.
// ----------------------------------------------------------------------------
module bitmap_contiguous_block_allocator #(
  parameter int NUM_BLOCKS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // operation [1:0], first_block [12:2], length [23:13]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,
  // run_start [10:0], run_length [21:11], zero fill [23:22]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);
  import bcba_pkg::*;

  localparam int ROWS = (NUM_BLOCKS + 7) / 8;
  localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int EW   = $clog2(NUM_BLOCKS + 1);
  localparam int PW   = ((EW > 12) ? EW : 12) + 1;
  localparam int RCW  = PW - 3;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_SCAN  = 4'd2;
  localparam logic [3:0] ST_FIN   = 4'd3;
  localparam logic [3:0] ST_WSET  = 4'd4;
  localparam logic [3:0] ST_WCHK  = 4'd5;
  localparam logic [3:0] ST_WRD   = 4'd6;
  localparam logic [3:0] ST_WWR   = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  logic [3:0]     state;
  logic [RCW-1:0] row_cnt;
  logic [RCW-1:0] p_row;
  logic           p_valid;
  logic [FW-1:0]  blocks_in_use;
  logic [FW-1:0]  scan_n;
  logic [FW-1:0]  req_len;
  scan_st_t       st;
  logic [FW-1:0]  wfirst;
  logic [FW-1:0]  wcount;
  logic           wval;
  logic [PW-1:0]  wend;
  logic [PW-1:0]  wlast;
  logic [FW-1:0]  res_start;
  logic [FW-1:0]  res_len;

  logic [7:0]     mem [ROWS];
  logic [7:0]     rd_data;
  logic           wr_en;
  logic [7:0]     wr_data;
  logic [RAW-1:0] addr;

  logic [1:0]     in_op;
  logic [FW-1:0]  in_start;
  logic [FW-1:0]  in_len;
  logic [FW-1:0]  n_sat;
  logic [7:0]     nrows;
  logic [PW-1:0]  wfirst_ext;
  logic [PW-1:0]  wsum;
  logic [RCW-1:0] first_row;
  logic [RCW-1:0] last_row;
  logic [7:0]     wmask;
  scan_st_t       st_step;
  scan_hit_t      hit;
  scan_st_t       fin_st;
  logic [3:0]     idle_next;
  logic           out_load;

  assign in_op    = s_tdata[1:0];
  assign in_start = s_tdata[12:2];
  assign in_len   = s_tdata[23:13];

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // saturate to the map size, then round down to whole rows
  assign n_sat = (PW'(blocks_in_use) > PW'(NUM_BLOCKS)) ? FW'(NUM_BLOCKS) : blocks_in_use;
  assign nrows = scan_n[FW-1:3];

  assign wfirst_ext = PW'(wfirst);
  assign wsum       = wfirst_ext + PW'(wcount);
  assign first_row  = wfirst_ext[PW-1:3];
  assign last_row   = wlast[PW-1:3];

  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  always_comb begin
    case (in_op) inside
      OP_ALLOC:         idle_next = (in_len != '0) ? ST_SCAN : ST_DONE;
      OP_FREE, OP_MARK: idle_next = (in_start != '0) ? ST_WSET : ST_DONE;
      default:          idle_next = ST_DONE;
    endcase
  end

  always_comb begin
    wmask = 8'hFF;
    if (row_cnt == first_row) wmask = wmask & (8'hFF << wfirst[2:0]);
    if (row_cnt == last_row)  wmask = wmask & (8'hFF >> (3'd7 - wlast[2:0]));
  end

  assign addr    = row_cnt[RAW-1:0];
  assign wr_en   = (state == ST_CLEAR) || (state == ST_WWR);
  assign wr_data = (state == ST_CLEAR) ? 8'h00 :
                   wval ? (rd_data | wmask) : (rd_data & ~wmask);

  always_ff @(posedge clk) begin
    rd_data <= mem[addr];
    if (wr_en) mem[addr] <= wr_data;
  end

  bcba_scan_unit u_scan (
    .row_bits (rd_data),
    .base     ({p_row[FW-4:0], 3'b000}),
    .req_len  (req_len),
    .st_in    (st),
    .st_out   (st_step),
    .hit      (hit)
  );

  // fold in a run that reaches the end of the scanned area
  always_comb begin
    fin_st = st;
    if (st.run > st.best_len) begin
      fin_st.best_len   = st.run;
      fin_st.best_first = scan_n - st.run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      row_cnt       <= '0;
      p_valid       <= 1'b0;
      m_tvalid      <= 1'b0;
      blocks_in_use <= FW'(1024);
    end else begin
      if (cfg_valid) blocks_in_use <= cfg_data;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      p_valid <= (state == ST_SCAN) && (row_cnt < RCW'(nrows));

      unique case (state)
        ST_CLEAR: begin
          if (row_cnt == RCW'(ROWS - 1)) begin
            state <= ST_IDLE;
          end else begin
            row_cnt <= row_cnt + 1'b1;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            res_start <= '0;
            res_len   <= '0;
            req_len   <= in_len;
            scan_n    <= {n_sat[FW-1:3], 3'b000};
            st        <= '0;
            row_cnt   <= '0;
            wfirst    <= in_start - 1'b1;
            wcount    <= in_len;
            wval      <= (in_op == OP_MARK);
            state     <= idle_next;
          end
        end
        ST_SCAN: begin
          if (row_cnt < RCW'(nrows)) begin
            p_row   <= row_cnt;
            row_cnt <= row_cnt + 1'b1;
          end
          if (nrows == '0) begin
            state <= ST_FIN;
          end else if (p_valid) begin
            st <= st_step;
            if (hit.found) begin
              wfirst    <= hit.first;
              wcount    <= req_len;
              wval      <= 1'b1;
              res_start <= hit.first + 1'b1;
              res_len   <= req_len;
              state     <= ST_WSET;
            end else if (p_row + 1'b1 == RCW'(nrows)) begin
              state <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (fin_st.best_len != '0) begin
            wfirst    <= fin_st.best_first;
            wcount    <= fin_st.best_len;
            wval      <= 1'b1;
            res_start <= fin_st.best_first + 1'b1;
            res_len   <= fin_st.best_len;
            state     <= ST_WSET;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_WSET: begin
          wend  <= (wsum > PW'(NUM_BLOCKS)) ? PW'(NUM_BLOCKS) : wsum;
          state <= ST_WCHK;
        end
        ST_WCHK: begin
          if (wfirst_ext >= wend) begin
            state <= ST_DONE;
          end else begin
            wlast   <= wend - 1'b1;
            row_cnt <= first_row;
            state   <= ST_WRD;
          end
        end
        ST_WRD: begin
          state <= ST_WWR;
        end
        ST_WWR: begin
          if (row_cnt == last_row) begin
            state <= ST_DONE;
          end else begin
            row_cnt <= row_cnt + 1'b1;
            state   <= ST_WRD;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            m_tdata <= {2'b00, res_len, res_start};
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: verif/bitmap_contiguous_block_allocator_tb.sv
// ----------------------------------------------------------------------------
// bitmap_contiguous_block_allocator_tb
// Self-checking bench for the first-fit contiguous block allocator.
// ----------------------------------------------------------------------------
// A directed table covers zero-length, full-map, oversized, out-of-range and
// unused-code requests. Random phases follow, each under its own scan size.
// A local copy of the used map predicts every result not typed in the table. Both stream sides idle
// at random, and the scan size is only rewritten once all results are in.
// ----------------------------------------------------------------------------
module bitmap_contiguous_block_allocator_tb;
  import bcba_pkg::*;

  localparam int NBLK = 1024;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 204;
  localparam int DRAIN_CYCLES = 500;

  typedef struct packed {
    logic [1:0]    op;
    logic [FW-1:0] blk_first;
    logic [FW-1:0] len;
  } req_t;

  typedef struct packed {
    logic [FW-1:0] run_start;
    logic [FW-1:0] run_length;
  } run_t;

  typedef struct packed {
    req_t req;
    bit   typed;
    run_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data = '0;

  bit          used_map [NBLK];
  int unsigned scan_cfg;
  run_t        pending_runs [$];
  int          errors = 0;
  bit          steady = 1'b0;
  int          rx_wait = 0;

  // expected results are typed in only where they follow at a glance
  dir_row_t directed_rows [21] = '{
    '{'{OP_ALLOC,  11'd0,    11'd0},    1'b1, '{11'd0,    11'd0}},
    '{'{OP_ALLOC,  11'd0,    11'd1},    1'b1, '{11'd1,    11'd1}},
    '{'{OP_ALLOC,  11'd0,    11'd1024}, 1'b1, '{11'd2,    11'd1023}},
    '{'{OP_ALLOC,  11'd0,    11'd5},    1'b1, '{11'd0,    11'd0}},
    '{'{OP_FREE,   11'd1,    11'd1024}, 1'b1, '{11'd0,    11'd0}},
    '{'{OP_MARK,   11'd0,    11'd10},   1'b1, '{11'd0,    11'd0}},
    '{'{OP_UNUSED, 11'd2047, 11'd2047}, 1'b1, '{11'd0,    11'd0}},
    '{'{OP_ALLOC,  11'd0,    11'd2047}, 1'b1, '{11'd1,    11'd1024}},
    '{'{OP_FREE,   11'd1024, 11'd2047}, 1'b1, '{11'd0,    11'd0}},
    '{'{OP_FREE,   11'd2047, 11'd5},    1'b1, '{11'd0,    11'd0}},
    '{'{OP_ALLOC,  11'd0,    11'd3},    1'b1, '{11'd1024, 11'd1}},
    '{'{OP_FREE,   11'd10,   11'd4},    1'b1, '{11'd0,    11'd0}},
    '{'{OP_FREE,   11'd20,   11'd2},    1'b1, '{11'd0,    11'd0}},
    '{'{OP_ALLOC,  11'd0,    11'd2},    1'b0, '{11'd0,    11'd0}},
    '{'{OP_ALLOC,  11'd0,    11'd3},    1'b0, '{11'd0,    11'd0}},
    '{'{OP_ALLOC,  11'd0,    11'd1},    1'b0, '{11'd0,    11'd0}},
    '{'{OP_MARK,   11'd1,    11'd1024}, 1'b1, '{11'd0,    11'd0}},
    '{'{OP_FREE,   11'd1,    11'd2047}, 1'b1, '{11'd0,    11'd0}},
    '{'{OP_ALLOC,  11'd1365, 11'd682},  1'b0, '{11'd0,    11'd0}},
    '{'{OP_MARK,   11'd682,  11'd1365}, 1'b1, '{11'd0,    11'd0}},
    '{'{OP_FREE,   11'd1,    11'd1024}, 1'b1, '{11'd0,    11'd0}}
  };

  logic [10:0] phase_cfg [PHASES] = '{11'd2047, 11'd0, 11'd7, 11'd100, 11'd1023, 11'd1024};

  bitmap_contiguous_block_allocator #(.NUM_BLOCKS(NBLK)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // operation [1:0], first_block [12:2], length [23:13]
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // run_start [10:0], run_length [21:11]
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void set_run(input int unsigned first, input int unsigned count,
                                  input bit val);
    for (int unsigned k = 0; k < count; k++) begin
      if (first + k >= NBLK) break;
      used_map[first + k] = val;
    end
  endfunction

  // applies one request to the local map and returns the run it yields
  function automatic run_t find_and_claim_run(input req_t r);
    int unsigned n;
    int unsigned run_len;
    int unsigned best_len;
    int unsigned best_first;
    int unsigned first;
    bit          done;
    run_t        res;
    res = '0;
    run_len = 0;
    best_len = 0;
    best_first = 0;
    done = 1'b0;
    if (r.op == OP_ALLOC && r.len != 0) begin
      n = (scan_cfg > NBLK) ? NBLK : scan_cfg;
      n = n - (n % 8);
      for (int unsigned i = 0; i < n; i++) begin
        if (!used_map[i]) begin
          run_len++;
          if (run_len == r.len) begin
            first = i + 1 - r.len;
            set_run(first, 32'(r.len), 1'b1);
            res.run_start = FW'(first + 1);
            res.run_length = r.len;
            done = 1'b1;
            break;
          end
        end else begin
          if (run_len > best_len) begin
            best_len = run_len;
            best_first = i - run_len;
          end
          run_len = 0;
        end
      end
      if (!done) begin
        // a run that touches the end of the scanned area still counts
        if (run_len > best_len) begin
          best_len = run_len;
          best_first = n - run_len;
        end
        if (best_len != 0) begin
          set_run(best_first, best_len, 1'b1);
          res.run_start = FW'(best_first + 1);
          res.run_length = FW'(best_len);
        end
      end
    end else if ((r.op == OP_FREE || r.op == OP_MARK) && r.blk_first != 0) begin
      set_run(32'(r.blk_first) - 1, 32'(r.len), r.op == OP_MARK);
    end
    return res;
  endfunction

  function automatic int blocks_taken();
    int cnt;
    cnt = 0;
    foreach (used_map[i]) cnt += used_map[i];
    return cnt;
  endfunction

  function automatic req_t draw_request();
    req_t r;
    int   pick;
    pick = $urandom_range(0, 99);
    r.blk_first = FW'($urandom_range(1, NBLK));
    r.len = FW'($urandom_range(1, 16));
    if (blocks_taken() > 900 && pick < 60) begin
      r.op = OP_FREE;
      r.len = FW'($urandom_range(128, 512));
    end else if (pick < 3) begin
      r.op = OP_UNUSED;
      r.blk_first = FW'($urandom_range(0, 2047));
      r.len = FW'($urandom_range(0, 2047));
    end else if (pick < 50) begin
      r.op = OP_ALLOC;
      r.blk_first = FW'($urandom_range(0, 2047));
      pick = $urandom_range(0, 99);
      if (pick < 5) r.len = '0;
      else if (pick < 75) r.len = FW'($urandom_range(1, 16));
      else if (pick < 90) r.len = FW'($urandom_range(17, 128));
      else r.len = FW'($urandom_range(0, 2047));
    end else begin
      r.op = (pick < 82) ? OP_FREE : OP_MARK;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        r.blk_first = FW'($urandom_range(0, 2047));
        r.len = FW'($urandom_range(0, 2047));
      end else if (pick < 15) begin
        r.blk_first = '0;
      end else if (r.op == OP_FREE) begin
        r.len = FW'($urandom_range(1, 64));
      end
    end
    return r;
  endfunction

  task automatic send_item(input req_t r, input bit typed, input run_t want);
    int   gap;
    run_t got_pred;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {r.len, r.blk_first, r.op};
    do @(posedge clk); while (!s_tready);
    got_pred = find_and_claim_run(r);
    pending_runs.push_back(typed ? want : got_pred);
  endtask

  task automatic write_scan_size(input logic [10:0] val);
    s_tvalid <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    scan_cfg = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("error at %0t: %s got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  // result side: check each item, then draw its stall
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b1;
      rx_wait = 0;
    end else if (m_tvalid && m_tready) begin
      if (pending_runs.size() == 0) begin
        report_mismatch("result with none pending, run_start", m_tdata[10:0], 0);
      end else begin
        run_t exp_run;
        exp_run = pending_runs.pop_front();
        if (m_tdata[10:0] != exp_run.run_start)
          report_mismatch("run_start", m_tdata[10:0], exp_run.run_start);
        if (m_tdata[21:11] != exp_run.run_length)
          report_mismatch("run_length", m_tdata[21:11], exp_run.run_length);
      end
      rx_wait = steady ? 0 : $urandom_range(0, 3);
      if (rx_wait != 0) m_tready <= 1'b0;
    end else if (!m_tready) begin
      rx_wait = rx_wait - 1;
      if (rx_wait <= 0) m_tready <= 1'b1;
    end
  end

  initial begin
    scan_cfg = NBLK;
    foreach (used_map[i]) used_map[i] = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    write_scan_size(11'd1024);

    foreach (directed_rows[i])
      send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

    for (int p = 0; p < PHASES + 1; p++) begin
      // the last phase uses a random scan size
      write_scan_size(p < PHASES ? phase_cfg[p] : 11'($urandom_range(0, 2047)));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 40 == 0) steady = ($urandom_range(0, 3) == 0);
        send_item(draw_request(), 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("bitmap_contiguous_block_allocator: match");
    end else begin
      $display("bitmap_contiguous_block_allocator: mismatch");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("bitmap_contiguous_block_allocator: mismatch");
    $finish;
  end

endmodule
